@@ src/kease_pkg.sv @@
// ----------------------------------------------------------------------------
// kease_pkg: shared types and constants for the keyed ease-in/ease-out core
// Table size, fixed-point and beat-kind constants and the sequencer state type.
// ----------------------------------------------------------------------------
package kease_pkg;

    localparam int          MaxKeys   = 16;
    localparam logic [16:0] OneQ16    = 17'd65536;
    localparam logic        KindWrite = 1'b0;
    localparam logic        KindEval  = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD_FIRST,
        S_CHK_FIRST,
        S_RD_LAST,
        S_CHK_LAST,
        S_SEARCH,
        S_RD_NEXT,
        S_DIV_U,
        S_RD_EASE,
        S_NORM_IN,
        S_NORM_OUT,
        S_MUL,
        S_DIV_V,
        S_OUT
    } t_state;

endpackage

@@ src/keyed_ease_in_ease_out_core.sv @@
// ----------------------------------------------------------------------------
// keyed_ease_in_ease_out_core: keyed ease-in/ease-out fraction modifier
//
//  channel  | direction | beat contents
//  ---------+-----------+------------------------------------------------------
//  s_axis   | in        | tuser=kind, tdata=index,key,ease_in,ease_out,fraction
//  m_axis   | out       | tdata=modified_fraction,segment
//  cfg      | in        | i_cfg_wr_en / i_cfg_wr_data = key_count
//
// A write beat is stored as it is accepted, and the core stays ready. An evaluate
// beat runs the downward key search, up to four divisions (u, two weight
// normalisations, eased value) in the one shared restoring divider, and memory
// reads and sequencing before the next beat is accepted.
// Key search walks downwards one entry a cycle. Reset is synchronous, active
// low; no clearing pass. One item is worked on at a time; a held result only
// stalls the next evaluation at its output step, not the input.
// ----------------------------------------------------------------------------
module keyed_ease_in_ease_out_core #(
    parameter int MAX_KEYS = kease_pkg::MaxKeys
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_wr_en,
    input  logic [4:0]   i_cfg_wr_data,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // tdata: [3:0] entry_index, [35:4] entry_key, [52:36] entry_ease_in,
    //        [69:53] entry_ease_out, [101:70] fraction, [103:102] zero
    input  logic [103:0] s_axis_tdata,
    input  logic         s_axis_tuser,   // kind
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // tdata: [16:0] modified_fraction, [20:17] segment, [23:21] zero
    output logic [23:0]  m_axis_tdata
);
    localparam int AW = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
    localparam int NW = $clog2(MAX_KEYS + 1);

    // memory: key, ease_in, ease_out
    logic [65:0]   mem [MAX_KEYS];
    logic [65:0]   r_rd;
    logic [AW-1:0] rd_addr;

    kease_pkg::t_state r_state, n_state;
    logic [4:0]    r_kc;
    logic [NW-1:0] r_n;
    logic [AW-1:0] r_i, n_i;
    logic [AW-1:0] r_seg;
    logic signed [31:0] r_f, r_k0;
    logic [16:0]   r_u, r_ein, r_eout;
    logic [17:0]   r_sum;
    logic [1:0]    r_br, r_dsel;
    logic [48:0]   r_num;
    logic [47:0]   r_den;
    logic [48:0]   r_rem, r_q;
    logic [5:0]    r_cnt;
    logic          r_busy;
    logic          r_ovf;
    logic          r_ov;
    logic [16:0]   r_val;
    logic [16:0]   r_res;
    logic [3:0]    r_oseg;

    logic        acc_in, acc_out;
    logic [3:0]  in_idx;
    logic [16:0] w_in, w_out;
    logic signed [31:0] rd_key;

    assign acc_in  = s_axis_tvalid && s_axis_tready;
    assign acc_out = m_axis_tvalid && m_axis_tready;
    assign in_idx  = s_axis_tdata[3:0];
    assign w_in    = (s_axis_tdata[52:36] > kease_pkg::OneQ16) ? kease_pkg::OneQ16
                                                               : s_axis_tdata[52:36];
    assign w_out   = (s_axis_tdata[69:53] > kease_pkg::OneQ16) ? kease_pkg::OneQ16
                                                               : s_axis_tdata[69:53];
    assign rd_key  = r_rd[31:0];
    assign s_axis_tready = (r_state == kease_pkg::S_IDLE);

    always_ff @(posedge i_clk) begin
        if (acc_in && s_axis_tuser == kease_pkg::KindWrite
            && 32'(in_idx) < MAX_KEYS) begin
            mem[AW'(in_idx)] <= {w_out, w_in, s_axis_tdata[35:4]};
        end
        r_rd <= mem[rd_addr];
    end

    // divider: 49-bit numerator / 48-bit denominator, one bit per cycle
    logic [49:0] trial;
    assign trial = {r_rem[47:0], r_num[48]} - {2'b0, r_den};

    // next-state and read address
    logic [AW-1:0] nxt_seg;
    assign nxt_seg = (32'(r_seg) + 1 >= 32'(r_n)) ? '0 : AW'(32'(r_seg) + 1);

    always_comb begin
        n_state = r_state;
        n_i     = r_i;
        rd_addr = '0;
        unique case (r_state)
            kease_pkg::S_IDLE: begin
                if (acc_in && s_axis_tuser == kease_pkg::KindEval && r_kc != 0)
                    n_state = kease_pkg::S_RD_FIRST;
            end
            kease_pkg::S_RD_FIRST:  n_state = kease_pkg::S_CHK_FIRST;
            kease_pkg::S_CHK_FIRST: begin
                // segment 0: fetch the entry after it for its ease-in
                rd_addr = (r_n == 1) ? '0 : AW'(1);
                n_state = (r_n == 1 || r_f <= rd_key) ? kease_pkg::S_RD_EASE
                                                      : kease_pkg::S_RD_LAST;
            end
            kease_pkg::S_RD_LAST: begin
                rd_addr = AW'(r_n - 1'b1);
                n_state = kease_pkg::S_CHK_LAST;
            end
            kease_pkg::S_CHK_LAST: begin
                n_i = AW'(r_n - 2'd2);
                if (r_f >= rd_key) begin
                    rd_addr = AW'(r_n - 1'b1);
                    n_state = kease_pkg::S_RD_EASE;
                end else begin
                    rd_addr = n_i;
                    n_state = kease_pkg::S_SEARCH;
                end
            end
            kease_pkg::S_SEARCH: begin
                // r_rd holds key[r_i]
                rd_addr = r_i;
                if (r_f > rd_key || r_i == 0) begin
                    rd_addr = AW'(32'(r_i) + 1);
                    n_state = kease_pkg::S_RD_NEXT;
                end else begin
                    n_i     = r_i - 1'b1;
                    rd_addr = n_i;
                end
            end
            kease_pkg::S_RD_NEXT: n_state = kease_pkg::S_DIV_U;
            kease_pkg::S_DIV_U: begin
                rd_addr = nxt_seg;
                if (!r_busy) n_state = kease_pkg::S_RD_EASE;
            end
            kease_pkg::S_RD_EASE: begin
                rd_addr = r_seg;
                n_state = kease_pkg::S_NORM_IN;
            end
            kease_pkg::S_NORM_IN:  if (!r_busy) n_state = kease_pkg::S_NORM_OUT;
            kease_pkg::S_NORM_OUT: begin
                // stay while a normalising division runs or the second one is still to start
                if (!r_busy && r_dsel != 2'd1) n_state = kease_pkg::S_MUL;
            end
            kease_pkg::S_MUL:      n_state = kease_pkg::S_DIV_V;
            kease_pkg::S_DIV_V:    if (!r_busy) n_state = kease_pkg::S_OUT;
            kease_pkg::S_OUT:      if (!r_ov || m_axis_tready) n_state = kease_pkg::S_IDLE;
            default:               n_state = kease_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= kease_pkg::S_IDLE;
            r_kc    <= '0;
            r_busy  <= 1'b0;
            r_ov    <= 1'b0;
            r_dsel  <= 2'd0;
        end else begin
            r_state <= n_state;
            r_i     <= n_i;
            if (i_cfg_wr_en) r_kc <= i_cfg_wr_data;
            if (r_state == kease_pkg::S_OUT && (!r_ov || m_axis_tready)) begin
                r_ov   <= 1'b1;
                r_res  <= r_ovf ? kease_pkg::OneQ16 : r_val;
                r_oseg <= 4'(r_seg);
            end else if (acc_out) begin
                r_ov <= 1'b0;
            end
            if (r_busy) begin
                r_rem <= trial[49] ? {r_rem[47:0], r_num[48]} : trial[48:0];
                r_num <= {r_num[47:0], 1'b0};
                r_q   <= {r_q[47:0], ~trial[49]};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == 0) r_busy <= 1'b0;
            end
            unique case (r_state)
                kease_pkg::S_IDLE: begin
                    r_f <= s_axis_tdata[101:70];
                    r_n <= (32'(r_kc) > MAX_KEYS) ? NW'(MAX_KEYS) : NW'(r_kc);
                    r_ovf <= 1'b0;
                end
                kease_pkg::S_CHK_FIRST: begin
                    r_seg <= '0;
                    r_u   <= '0;
                    r_k0  <= rd_key;
                end
                kease_pkg::S_CHK_LAST: begin
                    r_seg <= AW'(r_n - 2'd2);
                    r_u   <= kease_pkg::OneQ16;
                end
                kease_pkg::S_SEARCH: begin
                    r_seg <= r_i;
                    r_k0  <= rd_key;
                end
                kease_pkg::S_RD_NEXT: begin
                    r_num  <= {1'b0, 48'(33'(r_f) - 33'(r_k0)) << 16};
                    r_den  <= 48'(33'(rd_key) - 33'(r_k0));
                    r_rem  <= '0;
                    r_cnt  <= 6'd48;
                    r_busy <= 1'b1;
                end
                kease_pkg::S_DIV_U: begin
                    if (!r_busy) r_u <= (r_q > 49'(kease_pkg::OneQ16)) ? kease_pkg::OneQ16
                                                                      : r_q[16:0];
                end
                kease_pkg::S_RD_EASE: begin
                    r_ein <= r_rd[48:32]; // next entry's ease_in
                end
                kease_pkg::S_NORM_IN: begin
                    if (r_dsel == 2'd0 && !r_busy) begin
                        r_eout <= r_rd[65:49];
                        r_sum  <= 18'(r_ein) + 18'(r_rd[65:49]);
                        if (18'(r_ein) + 18'(r_rd[65:49]) > 18'(kease_pkg::OneQ16)) begin
                            r_num  <= 49'(r_ein) << 16;
                            r_den  <= 48'(18'(r_ein) + 18'(r_rd[65:49]));
                            r_rem  <= '0;
                            r_cnt  <= 6'd48;
                            r_busy <= 1'b1;
                            r_dsel <= 2'd1;
                        end else r_dsel <= 2'd2;
                    end
                end
                kease_pkg::S_NORM_OUT: begin
                    if (r_dsel == 2'd1 && !r_busy) begin
                        r_ein  <= r_q[16:0];
                        r_num  <= 49'(r_eout) << 16;
                        r_den  <= 48'(r_sum);
                        r_rem  <= '0;
                        r_cnt  <= 6'd48;
                        r_busy <= 1'b1;
                        r_dsel <= 2'd3;
                    end else if (r_dsel == 2'd3 && !r_busy) begin
                        r_eout <= r_q[16:0];
                    end
                end
                kease_pkg::S_MUL: begin
                    r_dsel <= 2'd0;
                    if (r_u < r_eout) begin
                        r_br  <= 2'd0;
                        r_num <= 49'(34'(r_u) * 34'(r_u)) << 16;
                        r_den <= 48'(35'(r_eout) * 35'(18'h20000 - 18'(r_ein)
                                                  - 18'(r_eout)));
                    end else if (18'(r_u) < 18'(kease_pkg::OneQ16) - 18'(r_ein)) begin
                        r_br  <= 2'd1;
                        r_num <= 49'(18'({r_u, 1'b0}) - 18'(r_eout)) << 16;
                        r_den <= 48'(18'h20000 - 18'(r_ein) - 18'(r_eout));
                    end else if (r_ein == 0) begin
                        r_br  <= 2'd2;
                        r_num <= '0;
                        r_den <= 48'd1;
                    end else begin
                        r_br  <= 2'd3;
                        r_num <= 49'(34'(kease_pkg::OneQ16 - r_u)
                                    * 34'(kease_pkg::OneQ16 - r_u)) << 16;
                        r_den <= 48'(35'(r_ein) * 35'(18'h20000 - 18'(r_ein)
                                                 - 18'(r_eout)));
                    end
                    r_rem  <= '0;
                    r_cnt  <= 6'd48;
                    r_busy <= 1'b1;
                end
                kease_pkg::S_DIV_V: begin
                    if (!r_busy) begin
                        unique case (r_br)
                            2'd2: r_val <= r_u;
                            2'd3: r_val <= (r_q >= 49'(kease_pkg::OneQ16)) ? '0
                                         : kease_pkg::OneQ16 - r_q[16:0];
                            default: begin
                                r_val <= r_q[16:0];
                                r_ovf <= (r_q > 49'(kease_pkg::OneQ16));
                            end
                        endcase
                    end
                end
                default: ;
            endcase
            if (r_state == kease_pkg::S_RD_FIRST && r_n == 1) r_ovf <= 1'b0;
        end
    end

    // the ease read for S_RD_EASE: ease_in comes from the next entry, ease_out from r_seg
    // (r_rd during S_RD_EASE holds entry nxt_seg, during S_NORM_IN entry r_seg)

    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = {3'b0, r_oseg, r_res};

    a_out_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov |-> (r_res <= kease_pkg::OneQ16)) else $error("result above one");
    a_no_in_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != kease_pkg::S_IDLE) |-> !s_axis_tready) else $error("ready while busy");
    a_seg_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == kease_pkg::S_MUL) |-> (32'(r_seg) < MAX_KEYS)) else $error("segment");
    a_div_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == kease_pkg::S_IDLE) |-> !r_busy) else $error("divider busy in idle");
endmodule

@@ tb/keyed_ease_in_ease_out_core_test.sv @@
// ----------------------------------------------------------------------------
// keyed_ease_in_ease_out_core_test: self-checking bench for the ease core
// Loads key tables, evaluates fractions over several key counts and checks
// every result beat against an in-bench predictor, under random idling and stalls.
// ----------------------------------------------------------------------------
module keyed_ease_in_ease_out_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int StallLimit = 20000;

    typedef struct packed {
        logic [3:0]  seg;
        logic [16:0] mod_frac;
    } t_eased;

    typedef struct {
        logic        kind;
        logic [3:0]  idx;
        logic [31:0] key;
        logic [16:0] ein;
        logic [16:0] eout;
        logic [31:0] frac;
        bit          typed;     // expected result typed in below
        t_eased      res;
    } t_row;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_cfg_wr_en = 1'b0;
    logic [4:0]   i_cfg_wr_data = '0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [103:0] s_axis_tdata = '0;
    logic         s_axis_tuser = 1'b0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [23:0]  m_axis_tdata;

    keyed_ease_in_ease_out_core dut (.*);

    always #1 i_clk = ~i_clk;

    // predictor state
    logic signed [31:0] key_tab [kease_pkg::MaxKeys];
    logic [16:0]        ein_tab [kease_pkg::MaxKeys];
    logic [16:0]        eout_tab [kease_pkg::MaxKeys];
    logic [4:0]         key_cnt;
    bit                 written [kease_pkg::MaxKeys];

    t_eased pending_eased[$];
    int     errors = 0;
    int     evals_done = 0;
    int     writes_done = 0;
    int     idle_pct = 0;
    int     stall_pct = 0;
    bit     hold_off = 1'b0;
    int     quiet = 0;

    function automatic logic [16:0] clamp_weight(logic [16:0] w);
        return (w > kease_pkg::OneQ16) ? kease_pkg::OneQ16 : w;
    endfunction

    function automatic t_eased ease_fraction(logic signed [31:0] f);
        int unsigned n, i, seg;
        longint unsigned u, ein, eout, sum, d, num, den, q, val, r, term;
        t_eased e;
        n = (key_cnt > kease_pkg::MaxKeys) ? kease_pkg::MaxKeys : key_cnt;
        if (n == 1 || f <= key_tab[0]) begin
            seg = 0;
            u = 0;
        end else if (f >= key_tab[n-1]) begin
            seg = n - 2;
            u = 65536;
        end else begin
            i = n - 1;
            while (i > 0 && !(f > key_tab[i])) i--;
            seg = i;
            num = longint'(f) - longint'(key_tab[i]);
            den = longint'(key_tab[i+1]) - longint'(key_tab[i]);
            q = (den != 0) ? (num << 16) / den : 65536;
            u = (q > 65536) ? 65536 : q;
        end
        eout = eout_tab[seg];
        ein = ein_tab[(seg + 1) % n];
        sum = ein + eout;
        if (sum > 65536) begin
            ein = (ein << 16) / sum;
            eout = (eout << 16) / sum;
        end
        d = 131072 - ein - eout;
        if (u < eout) val = ((u * u) << 16) / (eout * d);
        else if (u < 65536 - ein) val = ((2 * u - eout) << 16) / d;
        else if (ein == 0) val = u;
        else begin
            r = 65536 - u;
            term = ((r * r) << 16) / (ein * d);
            val = (term >= 65536) ? 0 : 65536 - term;
        end
        if (val > 65536) val = 65536;
        e.mod_frac = val[16:0];
        e.seg = seg[3:0];
        return e;
    endfunction

    // Drive one beat; predict on acceptance. Valid stays up afterwards so that
    // the next beat can follow straight on; drain() drops it.
    task automatic send_beat(input t_row rw);
        while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= rw.kind;
        s_axis_tdata <= {2'b0, rw.frac, rw.eout, rw.ein, rw.key, rw.idx};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        if (rw.kind == kease_pkg::KindWrite) begin
            key_tab[rw.idx] = rw.key;
            ein_tab[rw.idx] = clamp_weight(rw.ein);
            eout_tab[rw.idx] = clamp_weight(rw.eout);
            written[rw.idx] = 1'b1;
            writes_done++;
        end else if (key_cnt != 0) begin
            t_eased e;
            e = ease_fraction(rw.frac);
            if (rw.typed && e !== rw.res) begin
                $error("typed row disagrees: mod_frac exp %0d pred %0d", rw.res.mod_frac,
                       e.mod_frac);
                errors++;
            end
            pending_eased.push_back(e);
            evals_done++;
        end
        @(negedge i_clk);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (pending_eased.size() != 0) @(negedge i_clk);
        repeat (300) @(negedge i_clk);   // a late evaluation without result
    endtask

    task automatic set_count(input logic [4:0] c);
        drain();
        i_cfg_wr_en <= 1'b1;
        i_cfg_wr_data <= c;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
        key_cnt = c;
    endtask

    function automatic t_row wr_row(int idx, logic [31:0] k, logic [16:0] ei, logic [16:0] eo);
        t_row r;
        r = '{kease_pkg::KindWrite, idx[3:0], k, ei, eo, $urandom(), 1'b0, '0};
        return r;
    endfunction

    function automatic t_row ev_row(logic [31:0] f, bit typed, int mf, int sg);
        t_row r;
        r = '{kease_pkg::KindEval, 4'($urandom()), $urandom(), 17'($urandom()),
              17'($urandom()), f, typed, '{mod_frac: mf[16:0], seg: sg[3:0]}};
        return r;
    endfunction

    // Non-descending table of n keys, some repeated, with random weights; odd weights above one.
    task automatic load_table(input int n);
        int base;
        t_row r;
        base = $urandom_range(0, 1) ? -$urandom_range(0, 200000) : $urandom_range(0, 200000);
        for (int j = 0; j < n; j++) begin
            base += $urandom_range(0, 9) == 0 ? 0 : $urandom_range(1, 150000);
            r = wr_row(j, base, $urandom_range(0, 3) == 0 ? 17'($urandom()) :
                       17'($urandom_range(0, 65536)), $urandom_range(0, 4) == 0 ?
                       17'($urandom()) : 17'($urandom_range(0, 65536)));
            send_beat(r);
        end
    endtask

    function automatic logic [31:0] pick_frac(int n);
        int lo, hi;
        lo = key_tab[0];
        hi = key_tab[(n > 0 ? n : 1) - 1];
        case ($urandom_range(0, 9))
            0: return $urandom();
            1: return key_tab[$urandom_range(0, n - 1)];
            default: return lo + int'($urandom_range(0, 99) * ((longint'(hi) - lo + 40) / 100)) - 20;
        endcase
    endfunction

    // directed rows
    t_row dir_rows[$];

    initial begin
        t_row r;
        int n;
        for (int j = 0; j < kease_pkg::MaxKeys; j++) written[j] = 1'b0;
        key_cnt = '0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // count zero: evaluate gives nothing; write out of reset
        dir_rows.push_back(ev_row(32'h8000_0000, 1'b0, 0, 0));
        dir_rows.push_back(wr_row(0, 32'h8000_0000, 17'h1FFFF, 17'd0));
        dir_rows.push_back(wr_row(1, 32'h0000_0000, 17'd0, 17'd65536));
        dir_rows.push_back(wr_row(2, 32'h0001_0000, 17'd32768, 17'h1FFFF));
        dir_rows.push_back(wr_row(3, 32'h7FFF_FFFF, 17'd65536, 17'd0));
        dir_rows.push_back(wr_row(15, 32'h7FFF_FFFF, 17'd0, 17'd0));
        foreach (dir_rows[k]) send_beat(dir_rows[k]);
        dir_rows.delete();

        set_count(5'd1);   // single key: u = 0, segment 0
        dir_rows.push_back(ev_row(32'h7FFF_FFFF, 1'b1, 0, 0));
        dir_rows.push_back(ev_row(32'h8000_0000, 1'b1, 0, 0));
        foreach (dir_rows[k]) send_beat(dir_rows[k]);
        dir_rows.delete();

        set_count(5'd4);
        dir_rows.push_back(ev_row(32'h8000_0000, 1'b1, 0, 0));
        dir_rows.push_back(ev_row(32'h7FFF_FFFF, 1'b1, 65536, 2));
        dir_rows.push_back(ev_row(32'h0000_8000, 1'b0, 0, 0));
        dir_rows.push_back(ev_row(32'hC000_0000, 1'b0, 0, 0));
        dir_rows.push_back(ev_row(32'h0000_0000, 1'b0, 0, 0));
        dir_rows.push_back(ev_row(32'h4000_0000, 1'b0, 0, 0));
        // unordered keys
        dir_rows.push_back(wr_row(2, 32'hFFFF_0000, 17'd100, 17'd200));
        dir_rows.push_back(ev_row(32'h0000_1000, 1'b0, 0, 0));
        dir_rows.push_back(ev_row(32'hFFFF_8000, 1'b0, 0, 0));
        foreach (dir_rows[k]) send_beat(dir_rows[k]);
        dir_rows.delete();

        // 16 and beyond-table counts
        load_table(16);
        set_count(5'd16);
        for (int j = 0; j < 4; j++) send_beat(ev_row(pick_frac(16), 1'b0, 0, 0));
        set_count(5'd31);
        for (int j = 0; j < 4; j++) send_beat(ev_row(pick_frac(16), 1'b0, 0, 0));

        // random phases
        for (int ph = 0; ph < 10; ph++) begin
            case (ph % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 71; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 71; end
                default: begin idle_pct = 34; stall_pct = 34; end
            endcase
            n = (ph == 4) ? 2 : $urandom_range(2, 16);
            if (ph == 9) n = 16;
            set_count(5'd0);
            load_table(n);
            set_count(ph == 7 ? 5'($urandom_range(17, 31)) : 5'(n));
            if (ph == 5) hold_off = 1'b1;
            for (int j = 0; j < 90; j++) begin
                if ($urandom_range(0, 14) == 0) begin
                    // rewrite a live entry's weights, or a spare one
                    r = wr_row($urandom_range(0, 15), 0, 17'($urandom()), 17'($urandom()));
                    r.key = key_tab[r.idx];
                    if (!written[r.idx]) r.key = $urandom();
                    send_beat(r);
                end else begin
                    send_beat(ev_row(pick_frac(n), 1'b0, 0, 0));
                end
                if (j == 45) drain();   // sender pause until all results in
            end
        end

        idle_pct = 0;
        stall_pct = 0;
        drain();
        $display("Covered %0d table writes and %0d evaluations over key counts 0..31,",
                 writes_done, evals_done);
        $display("with idle and stall phases and a long receiver hold-off.");
        if (errors == 0) $display("Simulation PASSED");
        else $display("Simulation FAILED");
        $finish;
    end

    // receiver
    initial begin
        forever begin
            @(negedge i_clk);
            if (hold_off) begin
                m_axis_tready <= 1'b0;
                repeat (3000) @(negedge i_clk);
                hold_off = 1'b0;
            end
            m_axis_tready <= !(stall_pct > 0 && $urandom_range(99) < stall_pct);
        end
    end

    // result check
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            t_eased got, want;
            got = t_eased'(m_axis_tdata[20:0]);
            if (pending_eased.size() == 0) begin
                $error("result beat with nothing expected: %h", m_axis_tdata);
                errors++;
            end else begin
                want = pending_eased.pop_front();
                if (got.mod_frac !== want.mod_frac) begin
                    $error("modified_fraction exp %0d got %0d", want.mod_frac, got.mod_frac);
                    errors++;
                end
                if (got.seg !== want.seg) begin
                    $error("segment exp %0d got %0d", want.seg, got.seg);
                    errors++;
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (!s_axis_tvalid && pending_eased.size() == 0)) quiet <= 0;
        else quiet <= quiet + 1;
        if (quiet >= StallLimit) begin
            $display("Simulation FAILED");
            $finish;
        end
    end
endmodule

@@ filelist.f @@
src/kease_pkg.sv
src/keyed_ease_in_ease_out_core.sv
tb/keyed_ease_in_ease_out_core_test.sv
